/* hdl/swtg_pkg.sv */
`default_nettype none

package swtg_pkg;

    localparam int unsigned TICKS_PER_SECOND = 1000000;
    localparam int unsigned US_PER_MS        = 1000;

    localparam int FREQ_W   = 16;
    localparam int LEN_W    = 16;
    localparam int HALF_W   = 19;
    localparam int HALVES_W = 24;

    localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
    localparam int PER_W  = (TPS_W > HALF_W + 1) ? TPS_W : HALF_W + 1;
    localparam int PH_W   = PER_W - 1;
    localparam int PROD_W = LEN_W + $clog2(US_PER_MS + 1);
    localparam int DIV_W  = (PER_W > PROD_W) ? PER_W : PROD_W;
    localparam int CNT_W  = $clog2(DIV_W + 1);

    localparam logic [HALF_W-1:0]   HALF_MAX   = {HALF_W{1'b1}};
    localparam logic [HALVES_W-1:0] HALVES_MAX = {{(HALVES_W-1){1'b1}}, 1'b0};
    localparam logic [HALVES_W-2:0] CYC_MAX    = {(HALVES_W-1){1'b1}};

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PERIOD,
        S_CYCLES
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

/* hdl/swtg_if.sv */
`default_nettype none

interface swtg_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [swtg_pkg::FREQ_W-1:0] tone_freq;
    logic [swtg_pkg::LEN_W-1:0]  tone_length;

    modport source (output valid, mode, tone_freq, tone_length, input ready);
    modport sink   (input valid, mode, tone_freq, tone_length, output ready);
endinterface

interface swtg_out_if;
    logic valid;
    logic ready;
    logic speaker_level;
    logic busy_res;

    modport source (output valid, speaker_level, busy_res, input ready);
    modport sink   (input valid, speaker_level, busy_res, output ready);
endinterface

`default_nettype wire

/* hdl/swtg_div.sv */
`default_nettype none

module swtg_div (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  swtg_pkg::t_div_req i_req,
    output swtg_pkg::t_div_rsp o_rsp
);
    import swtg_pkg::*;

    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DIV_W-1:0] r_dsr, n_dsr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;

    logic [DIV_W:0] w_trial;
    logic [DIV_W:0] w_diff;
    logic           w_ge;

    always_comb begin
        w_trial = {r_rem, r_quo[DIV_W-1]};
        w_diff  = w_trial - {1'b0, r_dsr};
        w_ge    = (w_trial >= {1'b0, r_dsr});

        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        n_cnt  = r_cnt;
        n_done = 1'b0;

        if (i_req.start) begin
            n_rem = '0;
            n_quo = i_req.dividend;
            n_dsr = i_req.divisor;
            n_cnt = CNT_W'(DIV_W);
        end else if (r_cnt != '0) begin
            n_rem  = w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
            n_quo  = {r_quo[DIV_W-2:0], w_ge};
            n_cnt  = r_cnt - CNT_W'(1);
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

/* hdl/square_wave_tone_generator.sv */
`default_nettype none

// Square-wave buzzer tone generator. A tick transaction (mode 0) stands for one
// microsecond and is taken every clock cycle while no start is being divided and
// the output register is free or being read; its result gives the speaker level
// and busy flag for that tick. A start transaction (mode 1) sets up a tone from
// tone_freq (Hz) and tone_length (ms): period = TICKS_PER_SECOND / freq, half
// period = period / 2, cycles = length * 1000 / period. A start runs two
// divisions on one shared restoring divider that retires one quotient bit per
// cycle; a start with zero frequency is ignored and answered from the present
// tone state. The input is not ready while a division runs. A start while a
// tone plays restarts it; a zero cycle count silences the speaker. One output
// register decouples the two sides.
module square_wave_tone_generator (
    input  wire        i_clk,
    input  wire        i_rst_n,
    swtg_in_if.sink    i_in,
    swtg_out_if.source o_out
);
    import swtg_pkg::*;

    t_state              r_state, n_state;
    logic [DIV_W-1:0]    r_prod, n_prod;
    logic [PER_W-1:0]    r_period, n_period;
    logic [HALF_W-1:0]   r_half, n_half;
    logic [HALF_W-1:0]   r_phase, n_phase;
    logic [HALVES_W-1:0] r_halves, n_halves;
    logic                r_level, n_level;
    logic                r_out_valid, n_out_valid;
    logic                r_out_level, n_out_level;
    logic                r_out_busy, n_out_busy;

    t_div_req            w_req;
    t_div_rsp            w_rsp;
    logic                w_in_ready;
    logic [HALF_W-1:0]   w_phase_inc;
    logic [HALVES_W-1:0] w_halves_dec;
    logic [PH_W-1:0]     w_half_full;

    swtg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_in_ready   = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
        w_phase_inc  = r_phase + HALF_W'(1);
        w_halves_dec = r_halves - HALVES_W'(1);
        w_half_full  = r_period[PER_W-1:1];

        n_state     = r_state;
        n_prod      = r_prod;
        n_period    = r_period;
        n_half      = r_half;
        n_phase     = r_phase;
        n_halves    = r_halves;
        n_level     = r_level;
        n_out_valid = r_out_valid;
        n_out_level = r_out_level;
        n_out_busy  = r_out_busy;

        w_req.start    = 1'b0;
        w_req.dividend = DIV_W'(TICKS_PER_SECOND);
        w_req.divisor  = DIV_W'(i_in.tone_freq);

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid && w_in_ready) begin
                    if (i_in.mode == MODE_START) begin
                        if (i_in.tone_freq != '0) begin
                            w_req.start = 1'b1;
                            n_prod      = DIV_W'(i_in.tone_length) * DIV_W'(US_PER_MS);
                            n_state     = S_PERIOD;
                        end else begin
                            n_out_valid = 1'b1;
                            n_out_level = r_level;
                            n_out_busy  = (r_halves != '0);
                        end
                    end else if (r_halves == '0) begin
                        n_level     = 1'b0;
                        n_out_valid = 1'b1;
                        n_out_level = 1'b0;
                        n_out_busy  = 1'b0;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_level = r_level;
                        n_out_busy  = 1'b1;
                        n_phase     = w_phase_inc;
                        if (w_phase_inc >= r_half) begin
                            n_phase  = '0;
                            n_halves = w_halves_dec;
                            n_level  = (w_halves_dec == '0) ? 1'b0 : !r_level;
                        end
                    end
                end
            end
            S_PERIOD: begin
                if (w_rsp.done) begin
                    n_period = w_rsp.quotient[PER_W-1:0];
                    if (w_rsp.quotient == '0) begin
                        n_half      = '0;
                        n_phase     = '0;
                        n_halves    = '0;
                        n_level     = 1'b0;
                        n_out_valid = 1'b1;
                        n_out_level = 1'b0;
                        n_out_busy  = 1'b0;
                        n_state     = S_IDLE;
                    end else begin
                        w_req.start    = 1'b1;
                        w_req.dividend = r_prod;
                        w_req.divisor  = w_rsp.quotient;
                        n_state        = S_CYCLES;
                    end
                end
            end
            S_CYCLES: begin
                if (w_rsp.done) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (w_rsp.quotient == '0 || w_half_full == '0) begin
                        n_half      = '0;
                        n_phase     = '0;
                        n_halves    = '0;
                        n_level     = 1'b0;
                        n_out_level = 1'b0;
                        n_out_busy  = 1'b0;
                    end else begin
                        n_half      = (w_half_full > PH_W'(HALF_MAX)) ? HALF_MAX
                                                                      : w_half_full[HALF_W-1:0];
                        n_halves    = (w_rsp.quotient > DIV_W'(CYC_MAX)) ? HALVES_MAX
                                    : {w_rsp.quotient[HALVES_W-2:0], 1'b0};
                        n_phase     = '0;
                        n_level     = 1'b1;
                        n_out_level = 1'b1;
                        n_out_busy  = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_half      <= '0;
            r_phase     <= '0;
            r_halves    <= '0;
            r_level     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_half      <= n_half;
            r_phase     <= n_phase;
            r_halves    <= n_halves;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod      <= n_prod;
        r_period    <= n_period;
        r_out_level <= n_out_level;
        r_out_busy  <= n_out_busy;
    end

    assign i_in.ready          = w_in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.speaker_level = r_out_level;
    assign o_out.busy_res      = r_out_busy;

    a_busy_has_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halves != '0) |-> (r_half != '0))
        else $error("tone active with zero half period");

    a_level_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level |-> (r_halves != '0))
        else $error("speaker high while idle");

    a_done_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_PERIOD || r_state == S_CYCLES))
        else $error("divider finished outside a divide step");

    a_no_accept_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready)
        else $error("input ready during a divide");

endmodule

`default_nettype wire
